/* hdl/cemi_interface_init_sequencer_defines.svh */
// Assertion macros shared by the sequencer RTL.
`ifndef CEMI_INTERFACE_INIT_SEQUENCER_DEFINES_SVH
`define CEMI_INTERFACE_INIT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CEMI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CEMI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cemi_pkg.sv */
// Types, codes and frame tables for the interface start-up sequencer.
`timescale 1ns / 1ps

package cemi_pkg;

    // Input word kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_SLOT  = 2'd1;
    localparam logic [1:0] KIND_FRAME = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    // Result word kinds
    localparam logic [2:0] RES_BYTE     = 3'd0;
    localparam logic [2:0] RES_FINISHED = 3'd1;
    localparam logic [2:0] RES_TIMEOUT  = 3'd2;
    localparam logic [2:0] RES_FRAME    = 3'd3;
    localparam logic [2:0] RES_SLOT     = 3'd4;

    // Finish status codes
    localparam logic [1:0] FIN_MATCHED    = 2'd0;
    localparam logic [1:0] FIN_NO_ADDRESS = 2'd1;
    localparam logic [1:0] FIN_MISMATCH   = 2'd2;
    localparam logic [1:0] FIN_PROGRAMMED = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_OWN_ADDRESS   = 2'd0;
    localparam logic [1:0] CFG_ADDRESS_GIVEN = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    localparam logic [31:0] TIMEOUT_RESET = 32'd3000;

    // Message codes and frame bytes
    localparam logic [7:0] MC_PROP_WRITE   = 8'hF6;
    localparam logic [7:0] MC_PROP_READ    = 8'hFC;
    localparam logic [7:0] MC_READ_CON     = 8'hFB;
    localparam logic [7:0] MC_WRITE_CON    = 8'hF5;
    localparam logic [7:0] OBJ_CEMI_SRV    = 8'h08;
    localparam logic [7:0] OBJ_INSTANCE    = 8'h01;
    localparam logic [7:0] PID_MODE_SELECT = 8'h34;
    localparam logic [7:0] PID_SUBNET      = 8'h39;
    localparam logic [7:0] PID_DEVICE      = 8'h3A;
    localparam logic [7:0] ELEM_COUNT      = 8'h10;
    localparam logic [7:0] START_INDEX     = 8'h01;

    localparam logic [7:0]  LEN_READ_CON  = 8'd8;
    localparam logic [7:0]  LEN_WRITE_CON = 8'd7;
    localparam logic [15:0] ADDR_NONE     = 16'h0000;
    localparam logic [15:0] ADDR_ALL_ONES = 16'hFFFF;

    // Byte index of the last byte of a run
    localparam logic [2:0] IDX_LAST_LONG  = 3'd7;
    localparam logic [2:0] IDX_LAST_SHORT = 3'd6;
    localparam logic [2:0] IDX_SINGLE     = 3'd0;

    typedef enum logic [2:0] {
        STEP_MODE      = 3'd0,
        STEP_SUBNET    = 3'd1,
        STEP_DEVICE    = 3'd2,
        STEP_DECIDE    = 3'd3,
        STEP_WR_SUBNET = 3'd4,
        STEP_WR_DEVICE = 3'd5,
        STEP_FINISH    = 3'd6
    } t_step;

    typedef enum logic [3:0] {
        OP_REQ_MODE,
        OP_REQ_SUBNET,
        OP_REQ_DEVICE,
        OP_WR_SUBNET,
        OP_WR_DEVICE,
        OP_FINISH,
        OP_TIMEOUT,
        OP_FRAME,
        OP_SLOT
    } t_op;

    // One queued command from front to back
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [1:0] status;
    } t_cmd;

    function automatic logic is_request(input t_op op);
        return (op == OP_REQ_MODE) || (op == OP_REQ_SUBNET) || (op == OP_REQ_DEVICE) ||
               (op == OP_WR_SUBNET) || (op == OP_WR_DEVICE);
    endfunction

    function automatic logic [2:0] op_last_idx(input t_op op);
        logic [2:0] idx;
        unique case (op)
            OP_REQ_MODE, OP_WR_SUBNET, OP_WR_DEVICE: idx = IDX_LAST_LONG;
            OP_REQ_SUBNET, OP_REQ_DEVICE:            idx = IDX_LAST_SHORT;
            default:                                 idx = IDX_SINGLE;
        endcase
        return idx;
    endfunction

    function automatic logic [2:0] result_kind_of(input t_op op);
        logic [2:0] rk;
        unique case (op)
            OP_FINISH:  rk = RES_FINISHED;
            OP_TIMEOUT: rk = RES_TIMEOUT;
            OP_FRAME:   rk = RES_FRAME;
            OP_SLOT:    rk = RES_SLOT;
            default:    rk = RES_BYTE;
        endcase
        return rk;
    endfunction

    // Byte idx of a property request frame; data is the value byte
    function automatic logic [7:0] frame_byte(input t_op op, input logic [2:0] idx,
                                              input logic [7:0] data);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = ((op == OP_REQ_SUBNET) || (op == OP_REQ_DEVICE)) ?
                      MC_PROP_READ : MC_PROP_WRITE;
            3'd1: b = 8'h00;
            3'd2: b = (op == OP_REQ_MODE) ? OBJ_CEMI_SRV : 8'h00;
            3'd3: b = OBJ_INSTANCE;
            3'd4: b = (op == OP_REQ_MODE) ? PID_MODE_SELECT :
                      ((op == OP_REQ_SUBNET) || (op == OP_WR_SUBNET)) ? PID_SUBNET :
                      PID_DEVICE;
            3'd5: b = ELEM_COUNT;
            3'd6: b = START_INDEX;
            default: b = data;
        endcase
        return b;
    endfunction

endpackage

/* hdl/cemi_in_if.sv */
// Input word channel: valid/ready plus the input fields.
`timescale 1ns / 1ps

interface cemi_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] msg_code;
    logic [7:0] frame_length;
    logic [7:0] prop_id;
    logic [7:0] prop_value;

    modport source (output valid, kind, msg_code, frame_length, prop_id, prop_value,
                    input ready);
    modport sink   (input valid, kind, msg_code, frame_length, prop_id, prop_value,
                    output ready);
endinterface

/* hdl/cemi_out_if.sv */
// Result word channel: valid/ready plus the result fields.
`timescale 1ns / 1ps

interface cemi_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] result_kind;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic [1:0] finish_status;

    modport source (output valid, result_kind, out_byte, last_of_run, finish_status,
                    input ready);
    modport sink   (input valid, result_kind, out_byte, last_of_run, finish_status,
                    output ready);
endinterface

/* hdl/cemi_cfg_if.sv */
// Configuration write channel: valid/ready, register index and write data.
`timescale 1ns / 1ps

interface cemi_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/cemi_interface_init_sequencer.sv */
// Top level of the interface start-up sequencer.
//
// Channels: i_in takes input words (start, send slot, received frame, timer tick),
// o_out gives result words, i_cfg writes own_address (0), address_given (1) and
// timeout_ticks (2); writes to index 3 are ignored. i_cfg is always ready.
// A word is accepted at a clock edge with valid and ready both high.
// An accepted input word's command is written to the queue at the accepting edge;
// its first result word then loads the output register when the back end reaches it.
// A request frame streams as 7 or 8 words, one per cycle unless o_out stalls;
// every other result is a single word. last_of_run marks the final word of each run.
// Throughput: one input word per cycle while the command queue has room
// (QUEUE_DEPTH entries); output runs at one word per cycle while o_out.ready
// is high, through the single byte-serial back end.
// Stall: when o_out.ready is low the output register holds its word, the back
// end waits and the queue fills; i_in.ready drops only when the queue is full.
// Reset (synchronous, active low): start-up idle, timer stopped, configuration
// at reset values, queue and output empty. No clearing pass is needed.
`timescale 1ns / 1ps

module cemi_interface_init_sequencer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cemi_in_if.sink     i_in,
    cemi_out_if.source  o_out,
    cemi_cfg_if.sink    i_cfg
);

    logic           w_q_push;
    cemi_pkg::t_cmd w_q_cmd;
    logic           w_q_pop;
    cemi_pkg::t_cmd w_q_head;
    logic           w_q_empty;
    logic           w_q_full;

    // front: classifies words, owns sequence state, timer and configuration
    cemi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_cmd  (w_q_cmd)
    );

    // command queue decouples the two sides
    cemi_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_cmd),
        .i_pop   (w_q_pop),
        .o_head  (w_q_head),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // back: turns each command into its word run
    cemi_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (w_q_head),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .o_out     (o_out)
    );

endmodule

/* hdl/cemi_front.sv */
// Front end: accepts input words, runs the start-up sequence, queues commands.
`timescale 1ns / 1ps

module cemi_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cemi_in_if.sink          i_in,
    cemi_cfg_if.sink         i_cfg,
    input  logic             i_q_full,
    output logic             o_q_push,
    output cemi_pkg::t_cmd   o_q_cmd
);

    // Configuration
    logic [15:0] r_own_address;
    logic        r_address_given;
    logic [31:0] r_timeout_ticks;

    // Sequence state
    logic                r_in_startup, n_in_startup;
    cemi_pkg::t_step     r_seq_step,   n_seq_step;
    logic [7:0]          r_subnet,     n_subnet;
    logic [7:0]          r_device,     n_device;
    logic [1:0]          r_reason,     n_reason;
    logic [31:0]         r_tleft,      n_tleft;

    logic           w_accept;
    logic           w_read_con;
    logic           w_write_con;
    logic           w_adv;
    logic [7:0]     w_subnet;
    logic [7:0]     w_device;
    logic [15:0]    w_dev_addr;
    cemi_pkg::t_cmd w_cmd;
    logic           w_push;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_full;
    assign w_accept    = i_in.valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address   <= '0;
            r_address_given <= 1'b0;
            r_timeout_ticks <= cemi_pkg::TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                cemi_pkg::CFG_OWN_ADDRESS:   r_own_address   <= i_cfg.data[15:0];
                cemi_pkg::CFG_ADDRESS_GIVEN: r_address_given <= i_cfg.data[0];
                cemi_pkg::CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Confirmation decode and captured property value
    always_comb begin
        w_read_con  = r_in_startup && (i_in.frame_length >= cemi_pkg::LEN_READ_CON) &&
                      (i_in.msg_code == cemi_pkg::MC_READ_CON);
        w_write_con = r_in_startup && (i_in.frame_length >= cemi_pkg::LEN_WRITE_CON) &&
                      (i_in.msg_code == cemi_pkg::MC_WRITE_CON);
        w_subnet = r_subnet;
        w_device = r_device;
        if (w_accept && (i_in.kind == cemi_pkg::KIND_FRAME) && w_read_con) begin
            if (i_in.prop_id == cemi_pkg::PID_SUBNET) begin
                w_subnet = i_in.prop_value;
            end else if (i_in.prop_id == cemi_pkg::PID_DEVICE) begin
                w_device = i_in.prop_value;
            end
        end
        w_dev_addr = {w_subnet, w_device};
    end

    // Output block: which command, if any, this word queues
    always_comb begin
        w_adv  = 1'b0;
        w_push = 1'b0;
        w_cmd  = '{op: cemi_pkg::OP_SLOT, data: 8'h00, status: cemi_pkg::FIN_MATCHED};
        if (w_accept) begin
            unique case (i_in.kind)
                cemi_pkg::KIND_START: ;
                cemi_pkg::KIND_SLOT: begin
                    if (r_in_startup) begin
                        w_adv = 1'b1;
                    end else begin
                        w_push = 1'b1;
                    end
                end
                cemi_pkg::KIND_FRAME: begin
                    if (w_read_con || w_write_con) begin
                        w_adv = 1'b1;
                    end else begin
                        w_push    = 1'b1;
                        w_cmd.op  = cemi_pkg::OP_FRAME;
                    end
                end
                cemi_pkg::KIND_TICK: begin
                    if (r_tleft == 32'd1) begin
                        w_push   = 1'b1;
                        w_cmd.op = cemi_pkg::OP_TIMEOUT;
                    end
                end
                default: ;
            endcase
        end
        if (w_adv) begin
            w_push = 1'b1;
            unique case (r_seq_step)
                cemi_pkg::STEP_MODE:      w_cmd.op = cemi_pkg::OP_REQ_MODE;
                cemi_pkg::STEP_SUBNET:    w_cmd.op = cemi_pkg::OP_REQ_SUBNET;
                cemi_pkg::STEP_DEVICE:    w_cmd.op = cemi_pkg::OP_REQ_DEVICE;
                cemi_pkg::STEP_DECIDE: begin
                    // decide step runs straight on to programming or finishing
                    priority if (!r_address_given) begin
                        w_cmd.op     = cemi_pkg::OP_FINISH;
                        w_cmd.status = cemi_pkg::FIN_NO_ADDRESS;
                    end else if ((w_dev_addr == cemi_pkg::ADDR_NONE) ||
                                 (w_dev_addr == cemi_pkg::ADDR_ALL_ONES)) begin
                        w_cmd.op   = cemi_pkg::OP_WR_SUBNET;
                        w_cmd.data = r_own_address[15:8];
                    end else if (w_dev_addr == r_own_address) begin
                        w_cmd.op     = cemi_pkg::OP_FINISH;
                        w_cmd.status = cemi_pkg::FIN_MATCHED;
                    end else begin
                        w_cmd.op     = cemi_pkg::OP_FINISH;
                        w_cmd.status = cemi_pkg::FIN_MISMATCH;
                    end
                end
                cemi_pkg::STEP_WR_SUBNET: begin
                    w_cmd.op   = cemi_pkg::OP_WR_SUBNET;
                    w_cmd.data = r_own_address[15:8];
                end
                cemi_pkg::STEP_WR_DEVICE: begin
                    w_cmd.op   = cemi_pkg::OP_WR_DEVICE;
                    w_cmd.data = r_own_address[7:0];
                end
                default: begin
                    w_cmd.op     = cemi_pkg::OP_FINISH;
                    w_cmd.status = r_reason;
                end
            endcase
        end
    end

    // Next-state block
    always_comb begin
        n_in_startup = r_in_startup;
        n_seq_step   = r_seq_step;
        n_subnet     = w_subnet;
        n_device     = w_device;
        n_reason     = r_reason;
        n_tleft      = r_tleft;
        if (w_accept && (i_in.kind == cemi_pkg::KIND_START)) begin
            n_in_startup = 1'b1;
            n_seq_step   = cemi_pkg::STEP_MODE;
            n_subnet     = 8'h00;
            n_device     = 8'h00;
            n_reason     = cemi_pkg::FIN_MATCHED;
            n_tleft      = r_timeout_ticks;
        end
        if (w_accept && (i_in.kind == cemi_pkg::KIND_TICK) && (r_tleft != 32'd0)) begin
            n_tleft = r_tleft - 32'd1;
            if (r_tleft == 32'd1) begin
                n_in_startup = 1'b0;
            end
        end
        if (w_adv) begin
            unique case (w_cmd.op)
                cemi_pkg::OP_REQ_MODE:   n_seq_step = cemi_pkg::STEP_SUBNET;
                cemi_pkg::OP_REQ_SUBNET: n_seq_step = cemi_pkg::STEP_DEVICE;
                cemi_pkg::OP_REQ_DEVICE: n_seq_step = cemi_pkg::STEP_DECIDE;
                cemi_pkg::OP_WR_SUBNET: begin
                    n_seq_step = cemi_pkg::STEP_WR_DEVICE;
                    n_reason   = cemi_pkg::FIN_PROGRAMMED;
                end
                cemi_pkg::OP_WR_DEVICE:  n_seq_step = cemi_pkg::STEP_FINISH;
                cemi_pkg::OP_FINISH: begin
                    n_seq_step   = cemi_pkg::STEP_FINISH;
                    n_in_startup = 1'b0;
                    n_tleft      = 32'd0;
                    n_reason     = w_cmd.status;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_startup <= 1'b0;
            r_seq_step   <= cemi_pkg::STEP_MODE;
            r_subnet     <= 8'h00;
            r_device     <= 8'h00;
            r_reason     <= cemi_pkg::FIN_MATCHED;
            r_tleft      <= 32'd0;
        end else begin
            r_in_startup <= n_in_startup;
            r_seq_step   <= n_seq_step;
            r_subnet     <= n_subnet;
            r_device     <= n_device;
            r_reason     <= n_reason;
            r_tleft      <= n_tleft;
        end
    end

    assign o_q_push = w_push;
    assign o_q_cmd  = w_cmd;

endmodule

/* hdl/cemi_fifo.sv */
// Short command queue between front and back.
`timescale 1ns / 1ps
`include "cemi_interface_init_sequencer_defines.svh"

module cemi_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cemi_pkg::t_cmd i_data,
    input  logic           i_pop,
    output cemi_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cemi_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CEMI_ASSERT_IMP(a_push_room, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `CEMI_ASSERT_IMP(a_pop_data, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `CEMI_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count lost a push")

endmodule

/* hdl/cemi_back.sv */
// Back end: expands queued commands into result words, one per cycle unless o_out stalls.
`timescale 1ns / 1ps
`include "cemi_interface_init_sequencer_defines.svh"

module cemi_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cemi_pkg::t_cmd i_head,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    cemi_out_if.source     o_out
);

    logic       r_valid;
    logic [2:0] r_idx;
    logic [2:0] r_kind;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_status;

    logic       w_load;
    logic       w_have;
    logic       w_last;

    assign w_load  = !r_valid || o_out.ready;
    assign w_have  = !i_q_empty;
    assign w_last  = (r_idx == cemi_pkg::op_last_idx(i_head.op));
    assign o_q_pop = w_load && w_have && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= w_have;
            if (w_have) begin
                r_idx <= w_last ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_load && w_have) begin
            r_kind   <= cemi_pkg::result_kind_of(i_head.op);
            r_byte   <= cemi_pkg::is_request(i_head.op) ?
                        cemi_pkg::frame_byte(i_head.op, r_idx, i_head.data) : 8'h00;
            r_last   <= w_last;
            r_status <= (i_head.op == cemi_pkg::OP_FINISH) ?
                        i_head.status : cemi_pkg::FIN_MATCHED;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.result_kind   = r_kind;
    assign o_out.out_byte      = r_byte;
    assign o_out.last_of_run   = r_last;
    assign o_out.finish_status = r_status;

    `CEMI_ASSERT_IMP(a_runs_are_bytes, i_clk, i_rst_n, r_valid && !r_last, r_kind == cemi_pkg::RES_BYTE, "multi-word run of a non-byte result")
    `CEMI_ASSERT_IMP(a_zero_byte, i_clk, i_rst_n, r_valid && (r_kind != cemi_pkg::RES_BYTE), r_byte == 8'h00, "byte set on non-byte result")
    `CEMI_ASSERT_IMP(a_run_held, i_clk, i_rst_n, r_idx != 3'd0, !i_q_empty, "command left queue mid-run")

endmodule

/* bench/cemi_seq_checker.sv */
// Checker for the start-up sequencer: predicts result words and compares them.
`timescale 1ns / 1ps

module cemi_seq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cemi_in_if          i_in,
    cemi_out_if         i_out,
    cemi_cfg_if         i_cfg,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } t_result_word;

    t_result_word expected_words[$];
    int unsigned  mismatches;

    // register copies
    logic [15:0] own_address;
    logic        address_given;
    logic [31:0] timeout_ticks;

    // sequencer state
    logic            in_startup;
    cemi_pkg::t_step step;
    logic [7:0]      subnet_byte;
    logic [7:0]      device_byte;
    logic [1:0]      finish_reason;
    logic [31:0]     ticks_left;

    function automatic void push_word(input logic [2:0] kind, input logic [7:0] data,
                                      input logic [1:0] status);
        t_result_word w;
        w.kind   = kind;
        w.data   = data;
        w.last   = 1'b0;
        w.status = status;
        expected_words.push_back(w);
    endfunction

    // Property request: 7 bytes, plus the value byte for the long form
    function automatic void push_request(input logic [7:0] code, input logic [7:0] obj,
                                         input logic [7:0] pid, input logic long_form,
                                         input logic [7:0] value);
        push_word(cemi_pkg::RES_BYTE, code, cemi_pkg::FIN_MATCHED);
        push_word(cemi_pkg::RES_BYTE, 8'h00, cemi_pkg::FIN_MATCHED);
        push_word(cemi_pkg::RES_BYTE, obj, cemi_pkg::FIN_MATCHED);
        push_word(cemi_pkg::RES_BYTE, cemi_pkg::OBJ_INSTANCE, cemi_pkg::FIN_MATCHED);
        push_word(cemi_pkg::RES_BYTE, pid, cemi_pkg::FIN_MATCHED);
        push_word(cemi_pkg::RES_BYTE, cemi_pkg::ELEM_COUNT, cemi_pkg::FIN_MATCHED);
        push_word(cemi_pkg::RES_BYTE, cemi_pkg::START_INDEX, cemi_pkg::FIN_MATCHED);
        if (long_form)
            push_word(cemi_pkg::RES_BYTE, value, cemi_pkg::FIN_MATCHED);
    endfunction

    // One sequence step; the decide step falls through to the next one
    task automatic advance_sequence();
        logic        done;
        logic [15:0] dev;
        done = 1'b0;
        while (!done) begin
            done = 1'b1;
            case (step)
                cemi_pkg::STEP_MODE: begin
                    step = cemi_pkg::STEP_SUBNET;
                    push_request(cemi_pkg::MC_PROP_WRITE, cemi_pkg::OBJ_CEMI_SRV,
                                 cemi_pkg::PID_MODE_SELECT, 1'b1, 8'h00);
                end
                cemi_pkg::STEP_SUBNET: begin
                    step = cemi_pkg::STEP_DEVICE;
                    push_request(cemi_pkg::MC_PROP_READ, 8'h00, cemi_pkg::PID_SUBNET,
                                 1'b0, 8'h00);
                end
                cemi_pkg::STEP_DEVICE: begin
                    step = cemi_pkg::STEP_DECIDE;
                    push_request(cemi_pkg::MC_PROP_READ, 8'h00, cemi_pkg::PID_DEVICE,
                                 1'b0, 8'h00);
                end
                cemi_pkg::STEP_DECIDE: begin
                    dev = {subnet_byte, device_byte};
                    if (!address_given) begin
                        finish_reason = cemi_pkg::FIN_NO_ADDRESS;
                        step = cemi_pkg::STEP_FINISH;
                    end else if (dev == cemi_pkg::ADDR_NONE ||
                                 dev == cemi_pkg::ADDR_ALL_ONES) begin
                        finish_reason = cemi_pkg::FIN_PROGRAMMED;
                        step = cemi_pkg::STEP_WR_SUBNET;
                    end else if (dev == own_address) begin
                        finish_reason = cemi_pkg::FIN_MATCHED;
                        step = cemi_pkg::STEP_FINISH;
                    end else begin
                        finish_reason = cemi_pkg::FIN_MISMATCH;
                        step = cemi_pkg::STEP_FINISH;
                    end
                    done = 1'b0;
                end
                cemi_pkg::STEP_WR_SUBNET: begin
                    step = cemi_pkg::STEP_WR_DEVICE;
                    push_request(cemi_pkg::MC_PROP_WRITE, 8'h00, cemi_pkg::PID_SUBNET,
                                 1'b1, own_address[15:8]);
                end
                cemi_pkg::STEP_WR_DEVICE: begin
                    step = cemi_pkg::STEP_FINISH;
                    push_request(cemi_pkg::MC_PROP_WRITE, 8'h00, cemi_pkg::PID_DEVICE,
                                 1'b1, own_address[7:0]);
                end
                default: begin
                    in_startup = 1'b0;
                    ticks_left = '0;
                    push_word(cemi_pkg::RES_FINISHED, 8'h00, finish_reason);
                end
            endcase
        end
    endtask

    task automatic predict_results(input logic [1:0] kind, input logic [7:0] code,
                                   input logic [7:0] len, input logic [7:0] pid,
                                   input logic [7:0] val);
        int unsigned base_count;
        base_count = expected_words.size();
        case (kind)
            cemi_pkg::KIND_START: begin
                in_startup    = 1'b1;
                step          = cemi_pkg::STEP_MODE;
                subnet_byte   = '0;
                device_byte   = '0;
                finish_reason = cemi_pkg::FIN_MATCHED;
                ticks_left    = timeout_ticks;
            end
            cemi_pkg::KIND_SLOT: begin
                if (in_startup)
                    advance_sequence();
                else
                    push_word(cemi_pkg::RES_SLOT, 8'h00, cemi_pkg::FIN_MATCHED);
            end
            cemi_pkg::KIND_FRAME: begin
                if (in_startup && code == cemi_pkg::MC_READ_CON &&
                    len >= cemi_pkg::LEN_READ_CON) begin
                    if (pid == cemi_pkg::PID_SUBNET)
                        subnet_byte = val;
                    else if (pid == cemi_pkg::PID_DEVICE)
                        device_byte = val;
                    advance_sequence();
                end else if (in_startup && code == cemi_pkg::MC_WRITE_CON &&
                             len >= cemi_pkg::LEN_WRITE_CON) begin
                    advance_sequence();
                end else begin
                    push_word(cemi_pkg::RES_FRAME, 8'h00, cemi_pkg::FIN_MATCHED);
                end
            end
            default: begin
                if (ticks_left != 0) begin
                    ticks_left = ticks_left - 1;
                    if (ticks_left == 0) begin
                        in_startup = 1'b0;
                        push_word(cemi_pkg::RES_TIMEOUT, 8'h00, cemi_pkg::FIN_MATCHED);
                    end
                end
            end
        endcase
        if (expected_words.size() > base_count)
            expected_words[expected_words.size() - 1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_result_word got;
        t_result_word want;
        if (!i_rst_n) begin
            own_address   = '0;
            address_given = 1'b0;
            timeout_ticks = cemi_pkg::TIMEOUT_RESET;
            in_startup    = 1'b0;
            step          = cemi_pkg::STEP_MODE;
            subnet_byte   = '0;
            device_byte   = '0;
            finish_reason = cemi_pkg::FIN_MATCHED;
            ticks_left    = '0;
            expected_words.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.kind   = i_out.result_kind;
                got.data   = i_out.out_byte;
                got.last   = i_out.last_of_run;
                got.status = i_out.finish_status;
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: result_kind %0d out_byte %0h",
                           got.kind, got.data);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
                        mismatches++;
                    end
                    if (got.data !== want.data) begin
                        $error("out_byte: expected %0h, got %0h", want.data, got.data);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d", want.last, got.last);
                        mismatches++;
                    end
                    if (got.status !== want.status) begin
                        $error("finish_status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    cemi_pkg::CFG_OWN_ADDRESS:   own_address   = i_cfg.data[15:0];
                    cemi_pkg::CFG_ADDRESS_GIVEN: address_given = i_cfg.data[0];
                    cemi_pkg::CFG_TIMEOUT_TICKS: timeout_ticks = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                predict_results(i_in.kind, i_in.msg_code, i_in.frame_length,
                                i_in.prop_id, i_in.prop_value);
        end
        o_pending    <= expected_words.size();
        o_fail_count <= mismatches;
    end

    initial begin
        mismatches   = 0;
        o_pending    = 0;
        o_fail_count = 0;
    end

endmodule

/* bench/tb.sv */
// Testbench top: stimulus, back-pressure and verdict for the start-up sequencer.
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_WORDS     = 160;
    localparam int NO_IDLE_TAIL     = 40;   // words at the end sent without gaps
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int HOLD_BURST       = 24;   // slot words offered during the long hold
    localparam int SETTLE_CYCLES    = 20;   // margin for words still in the queue and output register
    localparam int CYCLE_LIMIT      = 500000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cemi_in_if  in_ch ();
    cemi_out_if out_ch ();
    cemi_cfg_if cfg_ch ();

    int unsigned fail_count;
    int unsigned pending_words;
    int unsigned cycle_count = 0;
    int unsigned words_sent  = 0;
    int unsigned hold_requests = 0;
    logic        idle_on;
    logic [15:0] own_addr_tb;   // own address currently programmed, to craft matching reads

    cemi_interface_init_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    cemi_seq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side. Random ready bursts while idling is on; a long hold when the
    // stimulus asks for one, so the command queue fills and i_in.ready drops.
    initial begin
        int unsigned holds_served;
        holds_served = 0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_requests != holds_served) begin
                holds_served++;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one input word, with an optional idle burst first; returns at the
    // accepting edge with valid still high.
    task automatic send_word(input logic [1:0] kind, input logic [7:0] code,
                             input logic [7:0] len, input logic [7:0] pid,
                             input logic [7:0] val);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.msg_code     <= code;
        in_ch.frame_length <= len;
        in_ch.prop_id      <= pid;
        in_ch.prop_value   <= val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Stop offering and wait until every predicted word has come out. The extra
    // cycles let starts and ticks, which emit nothing, clear the pipeline.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    // Only called with the block idle
    task automatic configure(input logic [15:0] own, input logic given,
                             input logic [31:0] ticks);
        own_addr_tb = own;
        write_reg(cemi_pkg::CFG_OWN_ADDRESS, {16'($urandom), own});
        write_reg(cemi_pkg::CFG_ADDRESS_GIVEN, {31'($urandom), given});
        write_reg(cemi_pkg::CFG_TIMEOUT_TICKS, ticks);
        cfg_ch.valid <= 1'b0;
    endtask

    // Anything that may disturb a sequence: stray starts, tick bursts, slots,
    // confirmations with random length/property, arbitrary frames.
    task automatic send_noise();
        case ($urandom_range(0, 7))
            0: send_word(cemi_pkg::KIND_START, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
            1, 2: repeat ($urandom_range(1, 4))
                send_word(cemi_pkg::KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
            3: send_word(cemi_pkg::KIND_SLOT, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
            4: send_word(cemi_pkg::KIND_FRAME, cemi_pkg::MC_READ_CON, 8'($urandom),
                         8'($urandom), 8'($urandom));
            5: send_word(cemi_pkg::KIND_FRAME, cemi_pkg::MC_WRITE_CON, 8'($urandom),
                         8'($urandom), 8'($urandom));
            default: send_word(cemi_pkg::KIND_FRAME, 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom));
        endcase
    endtask

    // Well-formed start-up: start, slot, write-con, subnet read-con, device
    // read-con, then two write-cons for the programming path. Where no
    // programming happens the trailing confirmations fall to the normal path.
    // Slots may stand in for write-cons since they advance the sequence too.
    task automatic run_startup(input logic [15:0] dev, input int noise_pct);
        send_word(cemi_pkg::KIND_START, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
        for (int n = 0; n < 6; n++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_noise();
            case (n)
                0: send_word(cemi_pkg::KIND_SLOT, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
                2: send_word(cemi_pkg::KIND_FRAME, cemi_pkg::MC_READ_CON,
                             8'($urandom_range(cemi_pkg::LEN_READ_CON, 255)),
                             cemi_pkg::PID_SUBNET, dev[15:8]);
                3: send_word(cemi_pkg::KIND_FRAME, cemi_pkg::MC_READ_CON,
                             8'($urandom_range(cemi_pkg::LEN_READ_CON, 255)),
                             cemi_pkg::PID_DEVICE, dev[7:0]);
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        send_word(cemi_pkg::KIND_SLOT, 8'($urandom), 8'($urandom),
                                  8'($urandom), 8'($urandom));
                    else
                        send_word(cemi_pkg::KIND_FRAME, cemi_pkg::MC_WRITE_CON,
                                  8'($urandom_range(cemi_pkg::LEN_WRITE_CON, 255)),
                                  8'($urandom), 8'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        int unsigned random_start;
        int unsigned random_end;
        logic        hold_done;
        logic [15:0] own;
        logic [15:0] dev;
        logic [31:0] ticks;

        i_rst_n            <= 1'b0;
        idle_on            <= 1'b1;
        in_ch.valid        <= 1'b0;
        in_ch.kind         <= cemi_pkg::KIND_START;
        in_ch.msg_code     <= '0;
        in_ch.frame_length <= '0;
        in_ch.prop_id      <= '0;
        in_ch.prop_value   <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= cemi_pkg::CFG_OWN_ADDRESS;
        cfg_ch.data        <= '0;
        own_addr_tb        = '0;
        hold_done          = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed ----
        // Reset config: no address given, timeout 3000.
        // Outside start-up: slot and frames go to the normal path, tick is dropped.
        send_word(cemi_pkg::KIND_SLOT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(cemi_pkg::KIND_FRAME, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(cemi_pkg::KIND_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(cemi_pkg::KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // No address configured: finishes right after the device read
        run_startup(cemi_pkg::ADDR_NONE, 0);

        // Interface reports all-ones: own address gets programmed
        wait_drained();
        configure(16'h1234, 1'b1, 32'hFFFF_FFFF);
        run_startup(cemi_pkg::ADDR_ALL_ONES, 0);

        // Frames during start-up that are not confirmations: read-con one byte
        // short, write-con one byte short. Then a read-con of another property
        // advances without storing, and a start restarts mid-sequence.
        send_word(cemi_pkg::KIND_START, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(cemi_pkg::KIND_FRAME, cemi_pkg::MC_READ_CON,
                  cemi_pkg::LEN_READ_CON - 8'd1, cemi_pkg::PID_SUBNET, 8'hFF);
        send_word(cemi_pkg::KIND_FRAME, cemi_pkg::MC_WRITE_CON,
                  cemi_pkg::LEN_WRITE_CON - 8'd1, 8'h00, 8'h00);
        send_word(cemi_pkg::KIND_SLOT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(cemi_pkg::KIND_FRAME, cemi_pkg::MC_READ_CON, cemi_pkg::LEN_READ_CON,
                  8'h55, 8'hA5);
        send_word(cemi_pkg::KIND_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

        // Timeout of one tick: first tick times out, second is dropped
        wait_drained();
        configure(16'hFFFF, 1'b1, 32'd1);
        send_word(cemi_pkg::KIND_START, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(cemi_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(cemi_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00);

        // Zero timeout: timer never runs, start-up survives ticks
        wait_drained();
        configure(16'h0000, 1'b0, 32'd0);
        send_word(cemi_pkg::KIND_START, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(cemi_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(cemi_pkg::KIND_SLOT, 8'h00, 8'h00, 8'h00, 8'h00);

        // ---- random ----
        // Each phase: drain, new register set, a few start-up runs with noise.
        random_start = words_sent;
        random_end   = random_start + RANDOM_WORDS;
        while (words_sent < random_end) begin
            wait_drained();
            case ($urandom_range(0, 3))
                0: own = cemi_pkg::ADDR_NONE;
                1: own = cemi_pkg::ADDR_ALL_ONES;
                default: own = 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: ticks = 32'd0;
                1: ticks = 32'd1;
                2: ticks = 32'hFFFF_FFFF;
                3: ticks = $urandom;
                default: ticks = 32'($urandom_range(2, 40));   // short enough to expire
            endcase
            configure(own, 1'($urandom_range(0, 1)), ticks);

            // Long receiver hold once, with the sender pushing back to back,
            // then the sender waits for everything to come out.
            if (!hold_done && words_sent > random_start + 60) begin
                hold_requests++;
                idle_on <= 1'b0;
                repeat (HOLD_BURST)
                    send_word(cemi_pkg::KIND_SLOT, 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom));
                wait_drained();
                idle_on <= 1'b1;
                hold_done = 1'b1;
            end

            repeat ($urandom_range(2, 5)) begin
                if (words_sent + NO_IDLE_TAIL >= random_end)
                    idle_on <= 1'b0;
                case ($urandom_range(0, 4))
                    0: dev = own_addr_tb;
                    1: dev = cemi_pkg::ADDR_NONE;
                    2: dev = cemi_pkg::ADDR_ALL_ONES;
                    3: dev = {own_addr_tb[15:8], 8'($urandom)};
                    default: dev = 16'($urandom);
                endcase
                run_startup(dev, 20);
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
